// ===== design/bb3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and helpers of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    // Default frame limits and register reset values
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int WIDTH_RESET    = 1024;
    localparam int HEIGHT_RESET   = 768;

    // Field widths
    localparam int CFG_DATA_W = 11;
    localparam int WORD_W     = 32;
    localparam int RGB_W      = 24;
    localparam int CSUM_W     = 10;   // sum of three 8-bit channel values

    // Job queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_FREE_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        CFG_ACTIVE_WIDTH  = 2'd0,
        CFG_ACTIVE_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    // Column sum of one window column, per channel
    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } t_csum;

    // One blur job: the three window columns after the shift
    typedef struct packed {
        t_csum col0;
        t_csum col1;
        t_csum col2;
        logic  emit_last;    // last column: a second result follows
        logic  frame_last;   // that second result closes the frame
    } t_job;

    // Limit a written size to 2..hi
    function automatic logic [31:0] clamp_size(input logic [31:0] value,
                                               input logic [31:0] hi);
        if (value < 32'd2) begin
            return 32'd2;
        end
        if (value > hi) begin
            return hi;
        end
        return value;
    endfunction

endpackage

// ===== design/bb3_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3 channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bb3_pix_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [bb3_pkg::WORD_W-1:0] pixel_word;

    modport source (output valid, output opcode, output pixel_word, input ready);
    modport sink   (input valid, input opcode, input pixel_word, output ready);
endinterface

interface bb3_res_if;
    logic                       valid;
    logic                       ready;
    logic [bb3_pkg::WORD_W-1:0] blurred_word;
    logic                       frame_last;

    modport source (output valid, output blurred_word, output frame_last, input ready);
    modport sink   (input valid, input blurred_word, input frame_last, output ready);
endinterface

interface bb3_cfg_if;
    logic                           valid;
    logic                           ready;
    bb3_pkg::t_cfg_idx              index;
    logic [bb3_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bb3_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/bb3_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_front
// Frame position, line stores and column-sum window; issues blur jobs.
// ----------------------------------------------------------------------------
module bb3_front #(
    parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bb3_pix_if.sink                           i_pix,
    bb3_cfg_if.sink                           i_cfg,
    input  logic [bb3_pkg::QUEUE_FREE_W-1:0]  i_free,
    output logic                              o_push,
    output bb3_pkg::t_job                     o_job
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int SWW = CW + 1;
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int RGB = bb3_pkg::RGB_W;
    localparam int QFW = bb3_pkg::QUEUE_FREE_W;

    // Sizes in use, already clamped
    logic [SWW-1:0] r_wid, n_wid;
    logic [RW-1:0]  r_hgt, n_hgt;

    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;

    logic           accept;
    logic [CW-1:0]  c_eff, wid_m1;
    logic [RW-1:0]  r_eff;
    logic [RGB-1:0] a_px;
    logic           a_top_ok, a_mid_ok, a_first, a_emit, a_last, a_flast;

    // Second stage: line store data arrives
    logic           r_b_valid;
    logic [CW-1:0]  r_b_col;
    logic [RGB-1:0] r_b_px;
    logic           r_b_top_ok, r_b_mid_ok, r_b_first, r_b_emit, r_b_last, r_b_flast;

    logic [RGB-1:0] up_rd, mid_rd, b_top, b_mid;
    bb3_pkg::t_csum r_win [3];
    bb3_pkg::t_csum n_win [3];
    bb3_pkg::t_csum new_col;

    function automatic logic [bb3_pkg::CSUM_W-1:0] CSUM_W_EXT(input logic [7:0] v);
        return bb3_pkg::CSUM_W'(v);
    endfunction

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_wid = r_wid;
        n_hgt = r_hgt;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bb3_pkg::CFG_ACTIVE_WIDTH: begin
                    n_wid = SWW'(bb3_pkg::clamp_size(32'(i_cfg.data), 32'(MAX_WIDTH)));
                end
                bb3_pkg::CFG_ACTIVE_HEIGHT: begin
                    n_hgt = RW'(bb3_pkg::clamp_size(32'(i_cfg.data), 32'(MAX_HEIGHT)));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid <= SWW'(bb3_pkg::clamp_size(32'(bb3_pkg::WIDTH_RESET), 32'(MAX_WIDTH)));
            r_hgt <= RW'(bb3_pkg::clamp_size(32'(bb3_pkg::HEIGHT_RESET), 32'(MAX_HEIGHT)));
        end else begin
            r_wid <= n_wid;
            r_hgt <= n_hgt;
        end
    end

    // ---------------- stage A: classify ----------------
    // Leave room in the queue for the word already in stage B
    assign i_pix.ready = (i_free > QFW'(r_b_valid));
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        wid_m1   = CW'(r_wid - SWW'(1));
        c_eff    = ({1'b0, r_col} >= r_wid) ? wid_m1 : r_col;
        r_eff    = (r_row > r_hgt) ? r_hgt : r_row;
        a_px     = ((i_pix.opcode == bb3_pkg::OP_DRAIN) || (r_eff >= r_hgt))
                   ? '0 : i_pix.pixel_word[31:8];
        a_top_ok = (r_eff >= RW'(2));
        a_mid_ok = (r_eff != '0);
        a_first  = (c_eff == '0);
        a_emit   = a_mid_ok && !a_first;
        a_last   = (c_eff == wid_m1);
        a_flast  = (r_eff == r_hgt);
        if (a_last) begin
            n_col = '0;
            n_row = (r_eff >= r_hgt) ? '0 : r_eff + RW'(1);
        end else begin
            n_col = c_eff + CW'(1);
            n_row = r_eff;
        end
    end

    // ---------------- line stores ----------------
    bb3_ram #(.WIDTH(RGB), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_col),
        .i_wdata (mid_rd),
        .i_re    (accept),
        .i_raddr (c_eff),
        .o_rdata (up_rd)
    );

    bb3_ram #(.WIDTH(RGB), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_col),
        .i_wdata (r_b_px),
        .i_re    (accept),
        .i_raddr (c_eff),
        .o_rdata (mid_rd)
    );

    // ---------------- stage B: window ----------------
    always_comb begin
        b_top = r_b_top_ok ? up_rd : '0;
        b_mid = r_b_mid_ok ? mid_rd : '0;
        new_col.red   = CSUM_W_EXT(b_top[23:16]) + CSUM_W_EXT(b_mid[23:16])
                        + CSUM_W_EXT(r_b_px[23:16]);
        new_col.green = CSUM_W_EXT(b_top[15:8]) + CSUM_W_EXT(b_mid[15:8])
                        + CSUM_W_EXT(r_b_px[15:8]);
        new_col.blue  = CSUM_W_EXT(b_top[7:0]) + CSUM_W_EXT(b_mid[7:0])
                        + CSUM_W_EXT(r_b_px[7:0]);
        n_win = r_win;
        if (r_b_valid) begin
            if (r_b_first) begin
                n_win[0] = '0;
                n_win[1] = '0;
            end else begin
                n_win[0] = r_win[1];
                n_win[1] = r_win[2];
            end
            n_win[2] = new_col;
        end
    end

    assign o_push           = r_b_valid && r_b_emit;
    assign o_job.col0       = n_win[0];
    assign o_job.col1       = n_win[1];
    assign o_job.col2       = n_win[2];
    assign o_job.emit_last  = r_b_last;
    assign o_job.frame_last = r_b_flast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
            r_win[0]  <= '0;
            r_win[1]  <= '0;
            r_win[2]  <= '0;
        end else begin
            r_b_valid <= accept;
            r_win     <= n_win;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_col    <= c_eff;
            r_b_px     <= a_px;
            r_b_top_ok <= a_top_ok;
            r_b_mid_ok <= a_mid_ok;
            r_b_first  <= a_first;
            r_b_emit   <= a_emit;
            r_b_last   <= a_last;
            r_b_flast  <= a_flast;
        end
    end

    // Stage B only ever holds a word taken in the cycle before
    a_stage_b_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> $past(i_pix.valid && i_pix.ready))
        else $error("stage B holds a word that was not accepted");

    // A push never meets a queue without room
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_free != '0))
        else $error("job pushed into a full queue");
endmodule

// ===== design/bb3_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module bb3_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  bb3_pkg::t_job                     i_job,
    input  logic                              i_pop,
    output logic                              o_valid,
    output bb3_pkg::t_job                     o_head,
    output logic [bb3_pkg::QUEUE_FREE_W-1:0]  o_free
);
    localparam int QD  = bb3_pkg::QUEUE_DEPTH;
    localparam int QAW = $clog2(QD);
    localparam int QFW = bb3_pkg::QUEUE_FREE_W;

    bb3_pkg::t_job  r_mem [QD];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QFW-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_free  = QFW'(QD) - r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QAW'(QD - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QAW'(QD - 1)) ? '0 : r_rd + QAW'(1);
            end
            r_cnt <= r_cnt + QFW'(i_push) - QFW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QFW'(QD))
        else $error("queue count beyond depth");
endmodule

// ===== design/bb3_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_back
// Sums the window columns, divides by nine and drives the result register.
// ----------------------------------------------------------------------------
module bb3_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  bb3_pkg::t_job  i_head,
    output logic           o_pop,
    bb3_res_if.source      o_res
);
    // floor(x / 9) = (x * 7282) >> 16, exact for x below 29491
    localparam int          DIV9_SHIFT = 16;
    localparam logic [12:0] DIV9_MUL   = 13'd7282;

    logic        r_phase;      // second result of a last-column job
    logic        r_valid;
    logic [31:0] r_word;
    logic        r_flast;

    logic          load;
    bb3_pkg::t_csum c2;
    logic [11:0]   s_red, s_green, s_blue;

    function automatic logic [7:0] div9(input logic [11:0] s);
        logic [24:0] prod;
        prod = 25'(s) * 25'(DIV9_MUL);
        return prod[DIV9_SHIFT +: 8];
    endfunction

    always_comb begin
        c2      = r_phase ? '0 : i_head.col2;
        s_red   = 12'(r_phase ? i_head.col1.red   : i_head.col0.red)
                  + 12'(r_phase ? i_head.col2.red   : i_head.col1.red)   + 12'(c2.red);
        s_green = 12'(r_phase ? i_head.col1.green : i_head.col0.green)
                  + 12'(r_phase ? i_head.col2.green : i_head.col1.green) + 12'(c2.green);
        s_blue  = 12'(r_phase ? i_head.col1.blue  : i_head.col0.blue)
                  + 12'(r_phase ? i_head.col2.blue  : i_head.col1.blue)  + 12'(c2.blue);
    end

    assign load  = i_head_valid && (!r_valid || o_res.ready);
    assign o_pop = load && (r_phase || !i_head.emit_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= !r_phase && i_head.emit_last;
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word  <= {div9(s_red), div9(s_green), div9(s_blue), bb3_pkg::ALPHA_OPAQUE};
            r_flast <= r_phase && i_head.frame_last;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.blurred_word = r_word;
    assign o_res.frame_last   = r_flast;

    // The second phase only exists while a last-column job sits at the head
    a_phase_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_head_valid && i_head.emit_last))
        else $error("second result pending without a last-column job");
endmodule

// ===== design/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur over a raster-order RGBA8888 stream, divisor nine, alpha 0xFF.
// ----------------------------------------------------------------------------
//  Channel | Dir | Word carries                    | Taken when
//  i_pix   | in  | opcode, pixel_word              | i_pix.valid && i_pix.ready
//  o_res   | out | blurred_word, frame_last        | o_res.valid && o_res.ready
//  i_cfg   | in  | index (0 width, 1 height), data | i_cfg.valid && i_cfg.ready
//
//  One input word per clock while i_pix.ready is high; the job of the pixel
//  word that completes a neighbourhood goes through stage B and the queue
//  into the result register. The last column yields two results from one
//  word: the back loads that job twice, and the four-entry queue absorbs it.
//  i_pix.ready drops when the queue has no room for the word in stage B plus
//  one more; the front never stalls mid-word, so the line stores are read
//  once and written once per word.
//  Reset is synchronous, active low; no clearing pass is needed.
//  i_cfg.ready is always high.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bb3_pix_if.sink    i_pix,
    bb3_cfg_if.sink    i_cfg,
    bb3_res_if.source  o_res
);
    logic                              push, pop, head_valid;
    bb3_pkg::t_job                     job, head;
    logic [bb3_pkg::QUEUE_FREE_W-1:0]  free;

    // Front: track position, read and rotate the line stores, build the
    // column-sum window and hand a job over for every pixel with a result.
    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (i_cfg),
        .i_free  (free),
        .o_push  (push),
        .o_job   (job)
    );

    // Queue: decouple the front from output back-pressure.
    bb3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head),
        .o_free  (free)
    );

    // Back: add the window columns, divide by nine, hold the result word.
    bb3_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_res        (o_res)
    );

    // Hold the result stable while it waits
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.blurred_word)))
        else $error("stalled result changed");
endmodule
